// File: rtl/core/vcrb_pkg.sv
// types, register addresses and constants shared by the video chip register bank
`timescale 1ns / 1ps

package vcrb_pkg;

    localparam logic [7:0] LINE_PIXELS      = 8'd160;
    localparam logic [7:0] BLANK_CLOCKS     = 8'd68;
    localparam logic [7:0] POS_BLANK_PLAYER = 8'd2;
    localparam logic [7:0] POS_BLANK_OBJECT = 8'd1;
    localparam logic [7:0] POS_OFS_PLAYER   = 8'd4;
    localparam logic [7:0] POS_OFS_OBJECT   = 8'd3;

    localparam int NUM_OBJECTS = 5;
    localparam int NUM_LATCHES = 15;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_HIT   = 2'd2;

    // write addresses
    localparam logic [5:0] ADDR_VSYNC  = 6'h00;
    localparam logic [5:0] ADDR_VBLANK = 6'h01;
    localparam logic [5:0] ADDR_WSYNC  = 6'h02;
    localparam logic [5:0] ADDR_RSYNC  = 6'h03;
    localparam logic [5:0] ADDR_NUSIZ0 = 6'h04;
    localparam logic [5:0] ADDR_NUSIZ1 = 6'h05;
    localparam logic [5:0] ADDR_COLUP0 = 6'h06;
    localparam logic [5:0] ADDR_COLUP1 = 6'h07;
    localparam logic [5:0] ADDR_COLUPF = 6'h08;
    localparam logic [5:0] ADDR_COLUBK = 6'h09;
    localparam logic [5:0] ADDR_CTRLPF = 6'h0a;
    localparam logic [5:0] ADDR_REFP0  = 6'h0b;
    localparam logic [5:0] ADDR_REFP1  = 6'h0c;
    localparam logic [5:0] ADDR_PF0    = 6'h0d;
    localparam logic [5:0] ADDR_PF1    = 6'h0e;
    localparam logic [5:0] ADDR_PF2    = 6'h0f;
    localparam logic [5:0] ADDR_RESP0  = 6'h10;
    localparam logic [5:0] ADDR_RESP1  = 6'h11;
    localparam logic [5:0] ADDR_RESM0  = 6'h12;
    localparam logic [5:0] ADDR_RESM1  = 6'h13;
    localparam logic [5:0] ADDR_RESBL  = 6'h14;
    localparam logic [5:0] ADDR_AUDC0  = 6'h15;
    localparam logic [5:0] ADDR_AUDC1  = 6'h16;
    localparam logic [5:0] ADDR_AUDF0  = 6'h17;
    localparam logic [5:0] ADDR_AUDF1  = 6'h18;
    localparam logic [5:0] ADDR_AUDV0  = 6'h19;
    localparam logic [5:0] ADDR_AUDV1  = 6'h1a;
    localparam logic [5:0] ADDR_GRP0   = 6'h1b;
    localparam logic [5:0] ADDR_GRP1   = 6'h1c;
    localparam logic [5:0] ADDR_ENAM0  = 6'h1d;
    localparam logic [5:0] ADDR_ENAM1  = 6'h1e;
    localparam logic [5:0] ADDR_ENABL  = 6'h1f;
    localparam logic [5:0] ADDR_HMP0   = 6'h20;
    localparam logic [5:0] ADDR_HMP1   = 6'h21;
    localparam logic [5:0] ADDR_HMM0   = 6'h22;
    localparam logic [5:0] ADDR_HMM1   = 6'h23;
    localparam logic [5:0] ADDR_HMBL   = 6'h24;
    localparam logic [5:0] ADDR_RESMP0 = 6'h28;
    localparam logic [5:0] ADDR_RESMP1 = 6'h29;
    localparam logic [5:0] ADDR_HMOVE  = 6'h2a;
    localparam logic [5:0] ADDR_HMCLR  = 6'h2b;
    localparam logic [5:0] ADDR_CXCLR  = 6'h2c;

    // read addresses
    localparam logic [3:0] RADDR_LATCH_LAST = 4'h7;
    localparam logic [3:0] RADDR_INPT_LAST  = 4'hd;
    localparam logic [2:0] RADDR_NO_LO      = 3'd6;

    // latch numbers shown in bits 6 and 7 for the collision reads
    localparam logic [3:0] LO_LATCH [8] = '{4'd1, 4'd3, 4'd5, 4'd7,
                                            4'd9, 4'd11, 4'd0, 4'd14};
    localparam logic [3:0] HI_LATCH [8] = '{4'd0, 4'd2, 4'd4, 4'd6,
                                            4'd8, 4'd10, 4'd12, 4'd13};

    typedef struct packed {
        logic [1:0]  op;
        logic [5:0]  addr;
        logic [7:0]  data;
        logic [7:0]  hcount;
        logic [14:0] collision_hits;
        logic [5:0]  controller_lines;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       cpu_halt;
        logic       hcount_clear;
        logic       vcount_clear;
        logic [7:0] player0_pos;
        logic [7:0] player1_pos;
        logic [7:0] missile0_pos;
        logic [7:0] missile1_pos;
        logic [7:0] ball_pos;
    } t_out_item;

endpackage

// File: rtl/core/video_chip_register_bank.sv
// register bank of the video and sound chip: bus reads, writes and collision updates
//
//   channel | handshake                | payload
//   --------+--------------------------+-------------------------
//   in      | i_in_valid / o_in_ready  | i_in  (t_in_item)
//   out     | o_out_valid / i_out_ready| o_out (t_out_item)
//
// one item per cycle while the output is not stalled; a taken item is held in the input
// register, then decoded and its register update written into the result register
// synchronous active-low reset clears the register file and both valid flags, not the payloads
// a stalled output holds the result; the input register still takes one item if it is empty
`timescale 1ns / 1ps

module video_chip_register_bank (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  vcrb_pkg::t_in_item   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output vcrb_pkg::t_out_item  o_out
);

    localparam int N_OBJ = vcrb_pkg::NUM_OBJECTS;
    localparam int N_CX  = vcrb_pkg::NUM_LATCHES;

    // input stage
    logic                 r_in_vld;
    vcrb_pkg::t_in_item   r_in;
    // result stage
    logic                 r_out_vld;
    vcrb_pkg::t_out_item  r_out;
    vcrb_pkg::t_out_item  n_out;

    logic w_out_free;
    logic w_move;

    // register file
    logic              r_vsync,   n_vsync;
    logic              r_vblank,  n_vblank;
    logic [2:0]        r_nusiz    [2];
    logic [2:0]        n_nusiz    [2];
    logic [1:0]        r_msize    [2];
    logic [1:0]        n_msize    [2];
    logic [6:0]        r_color    [4];
    logic [6:0]        n_color    [4];
    logic [2:0]        r_pfmode,  n_pfmode;
    logic [1:0]        r_blsize,  n_blsize;
    logic              r_refl     [2];
    logic              n_refl     [2];
    logic [19:0]       r_pf,      n_pf;
    logic [3:0]        r_audc     [2];
    logic [3:0]        n_audc     [2];
    logic [4:0]        r_audf     [2];
    logic [4:0]        n_audf     [2];
    logic [3:0]        r_audv     [2];
    logic [3:0]        n_audv     [2];
    logic [7:0]        r_grp      [2];
    logic [7:0]        n_grp      [2];
    logic              r_enable   [3];
    logic              n_enable   [3];
    logic              r_lock     [2];
    logic              n_lock     [2];
    logic [7:0]        r_pos      [N_OBJ];
    logic [7:0]        n_pos      [N_OBJ];
    logic [3:0]        r_motion   [N_OBJ];
    logic [3:0]        n_motion   [N_OBJ];
    logic [N_CX-1:0]   r_cx,      n_cx;

    logic [7:0] w_rd;
    logic [7:0] w_resp_player;
    logic [7:0] w_resp_object;

    function automatic logic [7:0] f_reset_pos(input logic [7:0] hcount,
                                               input logic [7:0] blank_pos,
                                               input logic [7:0] offset);
        logic [7:0] sum;
        begin
            sum = hcount - vcrb_pkg::BLANK_CLOCKS + offset;
            if (hcount < vcrb_pkg::BLANK_CLOCKS) begin
                f_reset_pos = blank_pos;
            end else if (sum >= vcrb_pkg::LINE_PIXELS) begin
                f_reset_pos = sum - vcrb_pkg::LINE_PIXELS;
            end else begin
                f_reset_pos = sum;
            end
        end
    endfunction

    assign w_out_free  = !r_out_vld || i_out_ready;
    assign w_move      = r_in_vld && w_out_free;
    assign o_in_ready  = !r_in_vld || w_out_free;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    assign w_resp_player = f_reset_pos(r_in.hcount, vcrb_pkg::POS_BLANK_PLAYER,
                                       vcrb_pkg::POS_OFS_PLAYER);
    assign w_resp_object = f_reset_pos(r_in.hcount, vcrb_pkg::POS_BLANK_OBJECT,
                                       vcrb_pkg::POS_OFS_OBJECT);

    // read path
    always_comb begin
        logic [3:0] ra;
        ra   = r_in.addr[3:0];
        w_rd = r_in.data;
        if (ra <= vcrb_pkg::RADDR_LATCH_LAST) begin
            if (ra[2:0] != vcrb_pkg::RADDR_NO_LO) begin
                w_rd[6] = r_cx[vcrb_pkg::LO_LATCH[ra[2:0]]];
            end
            w_rd[7] = r_cx[vcrb_pkg::HI_LATCH[ra[2:0]]];
        end else if (ra <= vcrb_pkg::RADDR_INPT_LAST) begin
            w_rd[7] = r_in.controller_lines[ra[2:0]];
        end
    end

    // register update
    always_comb begin
        n_vsync  = r_vsync;
        n_vblank = r_vblank;
        n_nusiz  = r_nusiz;
        n_msize  = r_msize;
        n_color  = r_color;
        n_pfmode = r_pfmode;
        n_blsize = r_blsize;
        n_refl   = r_refl;
        n_pf     = r_pf;
        n_audc   = r_audc;
        n_audf   = r_audf;
        n_audv   = r_audv;
        n_grp    = r_grp;
        n_enable = r_enable;
        n_lock   = r_lock;
        n_pos    = r_pos;
        n_motion = r_motion;
        n_cx     = r_cx;

        n_out              = '0;
        n_out.read_data    = r_in.data;

        unique case (r_in.op)
            vcrb_pkg::OP_READ: begin
                n_out.read_data = w_rd;
            end
            vcrb_pkg::OP_HIT: begin
                n_cx = r_cx | r_in.collision_hits;
            end
            vcrb_pkg::OP_WRITE: begin
                unique case (r_in.addr)
                    vcrb_pkg::ADDR_VSYNC: begin
                        n_out.vcount_clear = r_vsync && !r_in.data[1];
                        n_vsync            = r_in.data[1];
                    end
                    vcrb_pkg::ADDR_VBLANK: n_vblank = r_in.data[1];
                    vcrb_pkg::ADDR_WSYNC:  n_out.cpu_halt = 1'b1;
                    vcrb_pkg::ADDR_RSYNC:  n_out.hcount_clear = 1'b1;
                    vcrb_pkg::ADDR_NUSIZ0, vcrb_pkg::ADDR_NUSIZ1: begin
                        n_nusiz[1'(r_in.addr - vcrb_pkg::ADDR_NUSIZ0)] = r_in.data[2:0];
                        n_msize[1'(r_in.addr - vcrb_pkg::ADDR_NUSIZ0)] = r_in.data[5:4];
                    end
                    vcrb_pkg::ADDR_COLUP0, vcrb_pkg::ADDR_COLUP1,
                    vcrb_pkg::ADDR_COLUPF, vcrb_pkg::ADDR_COLUBK: begin
                        n_color[2'(r_in.addr - vcrb_pkg::ADDR_COLUP0)] = r_in.data[7:1];
                    end
                    vcrb_pkg::ADDR_CTRLPF: begin
                        n_pfmode = r_in.data[2:0];
                        n_blsize = r_in.data[5:4];
                    end
                    vcrb_pkg::ADDR_REFP0, vcrb_pkg::ADDR_REFP1: begin
                        n_refl[1'(r_in.addr - vcrb_pkg::ADDR_REFP0)] = r_in.data[3];
                    end
                    vcrb_pkg::ADDR_PF0: n_pf[3:0]   = r_in.data[7:4];
                    vcrb_pkg::ADDR_PF1: n_pf[11:4]  = r_in.data;
                    vcrb_pkg::ADDR_PF2: n_pf[19:12] = r_in.data;
                    vcrb_pkg::ADDR_RESP0, vcrb_pkg::ADDR_RESP1: begin
                        n_pos[3'(r_in.addr - vcrb_pkg::ADDR_RESP0)] = w_resp_player;
                    end
                    vcrb_pkg::ADDR_RESM0, vcrb_pkg::ADDR_RESM1,
                    vcrb_pkg::ADDR_RESBL: begin
                        n_pos[3'(r_in.addr - vcrb_pkg::ADDR_RESP0)] = w_resp_object;
                    end
                    vcrb_pkg::ADDR_AUDC0, vcrb_pkg::ADDR_AUDC1: begin
                        n_audc[1'(r_in.addr - vcrb_pkg::ADDR_AUDC0)] = r_in.data[3:0];
                    end
                    vcrb_pkg::ADDR_AUDF0, vcrb_pkg::ADDR_AUDF1: begin
                        n_audf[1'(r_in.addr - vcrb_pkg::ADDR_AUDF0)] = r_in.data[4:0];
                    end
                    vcrb_pkg::ADDR_AUDV0, vcrb_pkg::ADDR_AUDV1: begin
                        n_audv[1'(r_in.addr - vcrb_pkg::ADDR_AUDV0)] = r_in.data[3:0];
                    end
                    vcrb_pkg::ADDR_GRP0, vcrb_pkg::ADDR_GRP1: begin
                        n_grp[1'(r_in.addr - vcrb_pkg::ADDR_GRP0)] = r_in.data;
                    end
                    vcrb_pkg::ADDR_ENAM0, vcrb_pkg::ADDR_ENAM1,
                    vcrb_pkg::ADDR_ENABL: begin
                        n_enable[2'(r_in.addr - vcrb_pkg::ADDR_ENAM0)] = r_in.data[1];
                    end
                    vcrb_pkg::ADDR_HMP0, vcrb_pkg::ADDR_HMP1, vcrb_pkg::ADDR_HMM0,
                    vcrb_pkg::ADDR_HMM1, vcrb_pkg::ADDR_HMBL: begin
                        n_motion[3'(r_in.addr - vcrb_pkg::ADDR_HMP0)] = r_in.data[7:4];
                    end
                    vcrb_pkg::ADDR_RESMP0, vcrb_pkg::ADDR_RESMP1: begin
                        n_lock[1'(r_in.addr - vcrb_pkg::ADDR_RESMP0)] = r_in.data[1];
                    end
                    vcrb_pkg::ADDR_HMOVE: begin
                        // subtract motion, wrapping round the visible line
                        for (int i = 0; i < N_OBJ; i++) begin
                            if (r_pos[i] >= {4'd0, r_motion[i]}) begin
                                n_pos[i] = r_pos[i] - {4'd0, r_motion[i]};
                            end else begin
                                n_pos[i] = r_pos[i] + vcrb_pkg::LINE_PIXELS
                                           - {4'd0, r_motion[i]};
                            end
                        end
                    end
                    vcrb_pkg::ADDR_HMCLR: begin
                        for (int i = 0; i < N_OBJ; i++) begin
                            n_motion[i] = '0;
                        end
                    end
                    vcrb_pkg::ADDR_CXCLR: n_cx = '0;
                    default: ;
                endcase
            end
            default: ;
        endcase

        n_out.player0_pos  = n_pos[0];
        n_out.player1_pos  = n_pos[1];
        n_out.missile0_pos = n_pos[2];
        n_out.missile1_pos = n_pos[3];
        n_out.ball_pos     = n_pos[4];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_vsync   <= 1'b0;
            r_vblank  <= 1'b0;
            r_nusiz   <= '{default: '0};
            r_msize   <= '{default: '0};
            r_color   <= '{default: '0};
            r_pfmode  <= '0;
            r_blsize  <= '0;
            r_refl    <= '{default: '0};
            r_pf      <= '0;
            r_audc    <= '{default: '0};
            r_audf    <= '{default: '0};
            r_audv    <= '{default: '0};
            r_grp     <= '{default: '0};
            r_enable  <= '{default: '0};
            r_lock    <= '{default: '0};
            r_pos     <= '{default: '0};
            r_motion  <= '{default: '0};
            r_cx      <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (w_move) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (w_move) begin
                r_vsync  <= n_vsync;
                r_vblank <= n_vblank;
                r_nusiz  <= n_nusiz;
                r_msize  <= n_msize;
                r_color  <= n_color;
                r_pfmode <= n_pfmode;
                r_blsize <= n_blsize;
                r_refl   <= n_refl;
                r_pf     <= n_pf;
                r_audc   <= n_audc;
                r_audf   <= n_audf;
                r_audv   <= n_audv;
                r_grp    <= n_grp;
                r_enable <= n_enable;
                r_lock   <= n_lock;
                r_pos    <= n_pos;
                r_motion <= n_motion;
                r_cx     <= n_cx;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (w_move) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    // held item in the input register is not overwritten while stalled
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !w_move |=> r_in_vld && $stable(r_in))
        else $error("input item lost while stalled");

    // at most one strobe per item
    a_strobe_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> $onehot0({r_out.cpu_halt, r_out.hcount_clear, r_out.vcount_clear}))
        else $error("more than one strobe on one item");

    // positions stay on the visible line
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.player0_pos < vcrb_pkg::LINE_PIXELS) &&
                      (r_out.player1_pos < vcrb_pkg::LINE_PIXELS) &&
                      (r_out.missile0_pos < vcrb_pkg::LINE_PIXELS) &&
                      (r_out.missile1_pos < vcrb_pkg::LINE_PIXELS) &&
                      (r_out.ball_pos < vcrb_pkg::LINE_PIXELS))
        else $error("object position out of range");

    // a collision update only sets latches
    a_cx_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move && (r_in.op == vcrb_pkg::OP_HIT) |=> ((r_cx & $past(r_cx)) == $past(r_cx)))
        else $error("collision latch cleared by an update");

    // vertical clear only follows a set vsync flag
    a_vclr_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move && n_out.vcount_clear |-> r_vsync && !n_vsync)
        else $error("vertical clear without vsync fall");
`endif

endmodule
